// ----- hdl/wrms_pkg.sv -----
// Shared widths, constants and codes for the windowed RMS noise detector.
package wrms_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int COUNT_BITS  = 12;
    localparam int FRAC_BITS   = 8;

    localparam int LEVEL_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_BITS    = 2 * LEVEL_BITS + COUNT_BITS;
    localparam int ROOT_BITS  = (SQ_BITS + 1) / 2;
    localparam int NUM_BITS   = 2 * ROOT_BITS;
    localparam int REM_BITS   = ROOT_BITS + 3;
    localparam int ITER_BITS  = $clog2(NUM_BITS);
    localparam int PROD_BITS  = 2 * LEVEL_BITS;
    localparam int EMA_BITS   = PROD_BITS + 1;
    localparam int CFG_BITS   = (LEVEL_BITS > COUNT_BITS) ? LEVEL_BITS : COUNT_BITS;

    localparam int ALPHA_BITS = 9;
    localparam int ALPHA_FRAC = 8;
    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(256);

    localparam logic [COUNT_BITS-1:0] WINDOW_LEN_RESET     = COUNT_BITS'(100);
    localparam logic [ALPHA_BITS-1:0] SMOOTH_ALPHA_RESET   = ALPHA_BITS'(46);
    localparam logic [LEVEL_BITS-1:0] QUIET_LEVEL_RESET    = LEVEL_BITS'(38);
    localparam logic [LEVEL_BITS-1:0] LOUD_THRESHOLD_RESET = LEVEL_BITS'(102);

    typedef enum logic [1:0] {
        CFG_WINDOW_LEN     = 2'd0,
        CFG_SMOOTH_ALPHA   = 2'd1,
        CFG_QUIET_LEVEL    = 2'd2,
        CFG_LOUD_THRESHOLD = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_LOAD,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_ROOT,
        ST_EMA_NEW,
        ST_EMA_OLD,
        ST_EMA_SUM,
        ST_FINISH
    } state_t;

endpackage

// ----- hdl/windowed_rms_noise_detector_core.sv -----
// Windowed RMS noise detector: sequencer, shared divide/root unit and shared multiplier.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------------
//  in      | request   | in_valid / in_stall  | sample
//  out     | result    | out_valid / out_stall| rms_level, smoothed_level, relative_level,
//          |           |                      | is_quiet, state_changed
//  cfg     | write     | cfg_write            | cfg_index, cfg_data
//
//  A mean-phase sample is summed on acceptance; the last one goes on through the mean load and the mean divide.
//  A square-phase sample passes through the deviation, multiply and accumulate steps.
//  The last square-phase sample goes on through the divide steps, the root steps and the
//  smoothing and compare states (EMA new, EMA old, EMA sum, finish).
//  Divide and root share one compare-subtract unit; products share one multiplier.
//  Reset restores the register defaults and clears the window; in_stall holds while busy,
//  and a pending result waits in the output register while out_stall is high.
module windowed_rms_noise_detector_core
    import wrms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LEVEL_BITS-1:0] rms_level,
    output logic [LEVEL_BITS-1:0] smoothed_level,
    output logic [LEVEL_BITS-1:0] relative_level,
    output logic                  is_quiet,
    output logic                  state_changed,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data
);

    state_t                state_reg, state_next;
    logic                  phase_reg, phase_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [LEVEL_BITS-1:0] mean_reg, mean_next;
    logic [SQ_BITS-1:0]    sqsum_reg, sqsum_next;
    logic [LEVEL_BITS-1:0] smooth_reg, smooth_next;
    logic                  last_quiet_reg, last_quiet_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  last_reg, last_next;

    logic [COUNT_BITS-1:0] window_len_reg;
    logic [ALPHA_BITS-1:0] alpha_reg;
    logic [LEVEL_BITS-1:0] quiet_reg;
    logic [LEVEL_BITS-1:0] thresh_reg;

    logic [COUNT_BITS-1:0] div_n_reg, div_n_next;
    logic [LEVEL_BITS-1:0] dev_reg, dev_next;
    logic [PROD_BITS-1:0]  prod_reg, prod_next;
    logic [PROD_BITS-1:0]  ema_reg, ema_next;
    logic [NUM_BITS-1:0]   num_reg, num_next;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    logic [ROOT_BITS-1:0]  root_reg, root_next;
    logic [LEVEL_BITS-1:0] rms_reg, rms_next;
    logic [ITER_BITS-1:0]  iter_reg, iter_next;

    logic [LEVEL_BITS-1:0] rms_out_reg, rms_out_next;
    logic [LEVEL_BITS-1:0] sm_out_reg, sm_out_next;
    logic [LEVEL_BITS-1:0] rel_out_reg, rel_out_next;
    logic                  quiet_out_reg, quiet_out_next;
    logic                  changed_out_reg, changed_out_next;

    logic                  accept;
    logic [COUNT_BITS-1:0] len_eff;
    logic [COUNT_BITS-1:0] count_inc;
    logic [COUNT_BITS-1:0] n_cur;
    logic                  phase_end;
    logic [LEVEL_BITS-1:0] x_val;
    logic [ALPHA_BITS-1:0] alpha_c;
    logic [ALPHA_BITS-1:0] alpha_rest;
    logic [LEVEL_BITS-1:0] mul_a;
    logic [LEVEL_BITS-1:0] mul_b;
    logic [REM_BITS-1:0]   sub_a;
    logic [REM_BITS-1:0]   sub_b;
    logic [REM_BITS:0]     sub_diff;
    logic                  sub_ge;
    logic                  div_done;
    logic                  root_done;
    logic [EMA_BITS-1:0]   ema_sum;
    logic [EMA_BITS-1:0]   ema_shift;
    logic [LEVEL_BITS-1:0] rel_val;
    logic                  quiet_val;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign len_eff   = (window_len_reg == '0) ? COUNT_BITS'(1) : window_len_reg;
    assign count_inc = count_reg + COUNT_BITS'(1);
    assign n_cur     = (count_inc == '0) ? COUNT_BITS'(1) : count_inc;
    assign phase_end = (n_cur >= len_eff);
    assign x_val     = {sample, {FRAC_BITS{1'b0}}};
    assign alpha_c   = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_rest = ALPHA_ONE - alpha_c;
    assign div_done  = (iter_reg == ITER_BITS'(NUM_BITS - 1));
    assign root_done = (iter_reg == ITER_BITS'(ROOT_BITS - 1));

    // shared compare-subtract unit: one divide bit or one root bit per cycle
    always_comb
    begin
        if (state_reg == ST_ROOT)
        begin
            sub_a = {rem_reg[REM_BITS-3:0], num_reg[NUM_BITS-1:NUM_BITS-2]};
            sub_b = {1'b0, root_reg, 2'b01};
        end
        else
        begin
            sub_a = {rem_reg[REM_BITS-2:0], num_reg[NUM_BITS-1]};
            sub_b = REM_BITS'(div_n_reg);
        end
        sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge   = !sub_diff[REM_BITS];
    end

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_EMA_NEW:
            begin
                mul_a = LEVEL_BITS'(alpha_c);
                mul_b = rms_reg;
            end
            ST_EMA_OLD:
            begin
                mul_a = LEVEL_BITS'(alpha_rest);
                mul_b = smooth_reg;
            end
            default:
            begin
                mul_a = dev_reg;
                mul_b = dev_reg;
            end
        endcase
    end

    assign ema_sum   = {1'b0, ema_reg} + {1'b0, prod_reg}
                       + EMA_BITS'(1 << (ALPHA_FRAC - 1));
    assign ema_shift = ema_sum >> ALPHA_FRAC;
    assign rel_val   = (smooth_reg > quiet_reg) ? (smooth_reg - quiet_reg) : '0;
    assign quiet_val = (rel_val < thresh_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (phase_reg)
                        state_next = ST_SQUARE;
                    else if (phase_end)
                        state_next = ST_MEAN_LOAD;
                end
            end
            ST_MEAN_LOAD: state_next = ST_DIVIDE;
            ST_SQUARE:    state_next = ST_ACCUM;
            ST_ACCUM:     state_next = last_reg ? ST_DIVIDE : ST_IDLE;
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = phase_reg ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT:
            begin
                if (root_done)
                    state_next = ST_EMA_NEW;
            end
            ST_EMA_NEW:   state_next = ST_EMA_OLD;
            ST_EMA_OLD:   state_next = ST_EMA_SUM;
            ST_EMA_SUM:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!(out_valid_reg && out_stall))
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        mean_next        = mean_reg;
        sqsum_next       = sqsum_reg;
        smooth_next      = smooth_reg;
        last_quiet_next  = last_quiet_reg;
        out_valid_next   = out_valid_reg && out_stall;
        last_next        = last_reg;
        div_n_next       = div_n_reg;
        dev_next         = dev_reg;
        prod_next        = prod_reg;
        ema_next         = ema_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        root_next        = root_reg;
        rms_next         = rms_reg;
        iter_next        = iter_reg;
        rms_out_next     = rms_out_reg;
        sm_out_next      = sm_out_reg;
        rel_out_next     = rel_out_reg;
        quiet_out_next   = quiet_out_reg;
        changed_out_next = changed_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    div_n_next = n_cur;
                    last_next  = phase_end;
                    count_next = phase_end ? '0 : count_inc;
                    if (!phase_reg)
                        sum_next = sum_reg + SUM_BITS'(sample);
                    else
                        dev_next = (x_val >= mean_reg) ? (x_val - mean_reg)
                                                       : (mean_reg - x_val);
                end
            end
            ST_MEAN_LOAD:
            begin
                num_next  = NUM_BITS'({sum_reg, {FRAC_BITS{1'b0}}})
                            + NUM_BITS'(div_n_reg >> 1);
                rem_next  = '0;
                iter_next = '0;
                sum_next  = '0;
            end
            ST_SQUARE:
            begin
                prod_next = mul_a * mul_b;
            end
            ST_ACCUM:
            begin
                if (last_reg)
                begin
                    num_next   = NUM_BITS'(sqsum_reg + SQ_BITS'(prod_reg));
                    sqsum_next = '0;
                    rem_next   = '0;
                    iter_next  = '0;
                end
                else
                begin
                    sqsum_next = sqsum_reg + SQ_BITS'(prod_reg);
                end
            end
            ST_DIVIDE:
            begin
                rem_next  = sub_ge ? sub_diff[REM_BITS-1:0] : sub_a;
                num_next  = {num_reg[NUM_BITS-2:0], sub_ge};
                iter_next = iter_reg + ITER_BITS'(1);
                if (div_done)
                begin
                    iter_next = '0;
                    rem_next  = '0;
                    root_next = '0;
                    if (!phase_reg)
                    begin
                        mean_next  = (|num_next[NUM_BITS-1:LEVEL_BITS]) ? '1
                                     : num_next[LEVEL_BITS-1:0];
                        phase_next = 1'b1;
                    end
                end
            end
            ST_ROOT:
            begin
                rem_next  = sub_ge ? sub_diff[REM_BITS-1:0] : sub_a;
                root_next = {root_reg[ROOT_BITS-2:0], sub_ge};
                num_next  = {num_reg[NUM_BITS-3:0], 2'b00};
                iter_next = iter_reg + ITER_BITS'(1);
                if (root_done)
                    rms_next = (|root_next[ROOT_BITS-1:LEVEL_BITS]) ? '1
                               : root_next[LEVEL_BITS-1:0];
            end
            ST_EMA_NEW:
            begin
                prod_next = mul_a * mul_b;
            end
            ST_EMA_OLD:
            begin
                ema_next  = prod_reg;
                prod_next = mul_a * mul_b;
            end
            ST_EMA_SUM:
            begin
                smooth_next = (|ema_shift[EMA_BITS-1:LEVEL_BITS]) ? '1
                              : ema_shift[LEVEL_BITS-1:0];
            end
            ST_FINISH:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next   = 1'b1;
                    rms_out_next     = rms_reg;
                    sm_out_next      = smooth_reg;
                    rel_out_next     = rel_val;
                    quiet_out_next   = quiet_val;
                    changed_out_next = (quiet_val != last_quiet_reg);
                    last_quiet_next  = quiet_val;
                    phase_next       = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= 1'b0;
            count_reg      <= '0;
            sum_reg        <= '0;
            mean_reg       <= '0;
            sqsum_reg      <= '0;
            smooth_reg     <= '0;
            last_quiet_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            mean_reg       <= mean_next;
            sqsum_reg      <= sqsum_next;
            smooth_reg     <= smooth_next;
            last_quiet_reg <= last_quiet_next;
            out_valid_reg  <= out_valid_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RESET;
            alpha_reg      <= SMOOTH_ALPHA_RESET;
            quiet_reg      <= QUIET_LEVEL_RESET;
            thresh_reg     <= LOUD_THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WINDOW_LEN:     window_len_reg <= cfg_data[COUNT_BITS-1:0];
                CFG_SMOOTH_ALPHA:   alpha_reg      <= cfg_data[ALPHA_BITS-1:0];
                CFG_QUIET_LEVEL:    quiet_reg      <= cfg_data[LEVEL_BITS-1:0];
                CFG_LOUD_THRESHOLD: thresh_reg     <= cfg_data[LEVEL_BITS-1:0];
                default:            window_len_reg <= window_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        div_n_reg       <= div_n_next;
        dev_reg         <= dev_next;
        prod_reg        <= prod_next;
        ema_reg         <= ema_next;
        num_reg         <= num_next;
        rem_reg         <= rem_next;
        root_reg        <= root_next;
        rms_reg         <= rms_next;
        iter_reg        <= iter_next;
        rms_out_reg     <= rms_out_next;
        sm_out_reg      <= sm_out_next;
        rel_out_reg     <= rel_out_next;
        quiet_out_reg   <= quiet_out_next;
        changed_out_reg <= changed_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign rms_level      = rms_out_reg;
    assign smoothed_level = sm_out_reg;
    assign relative_level = rel_out_reg;
    assign is_quiet       = quiet_out_reg;
    assign state_changed  = changed_out_reg;

`ifndef ASSERT_OFF
    a_root_square_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT) |-> phase_reg)
        else $error("root step outside square phase");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish step");

    a_square_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg) |=> (state_reg == ST_SQUARE))
        else $error("square-phase request did not start the multiply");

    a_divide_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (rem_reg < REM_BITS'(div_n_reg)))
        else $error("divide remainder not below divisor");
`endif

endmodule
